@@ hw/rtl/mcoc_pkg.sv @@
// Shared widths, reset constants and sequencer state type for the
// median clock offset converter. No dependencies.
package mcoc_pkg;

    localparam int TIME_W = 64;
    localparam int WALL_W = 63;
    localparam int CFG_W  = 32;

    localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_CAPT,
        ST_SWEEP,
        ST_EVAL,
        ST_RESULT
    } state_t;

endpackage

@@ hw/rtl/mcoc_ring.sv @@
// Offset history memory: one write port, one read port with registered data.
// Depends on mcoc_pkg for the data width.
module mcoc_ring #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mcoc_pkg::TIME_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mcoc_pkg::TIME_W-1:0] rd_data
);
    import mcoc_pkg::*;

    logic [TIME_W-1:0] mem [0:DEPTH-1];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/median_clock_offset_converter.sv @@
// Median clock offset converter. An item without a new sample goes straight to the
// result. An item with a sample writes its offset to the ring, then tries candidates
// in turn until the median is found; one comparator sweeps the ring memory once per
// candidate (load, capture, sweep, evaluate). One item at a time.
// Reset: sequencer idle, interval 1000000, held offset zero, ring empty (not cleared).
// Depends on mcoc_pkg and mcoc_ring.
module median_clock_offset_converter #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mcoc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mcoc_pkg::TIME_W-1:0] s_mono_now_usec,
    input  logic [mcoc_pkg::WALL_W-1:0] s_wall_now_usec,
    input  logic [mcoc_pkg::TIME_W-1:0] s_boot_usec,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mcoc_pkg::TIME_W-1:0] m_unix_usec
);
    import mcoc_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  interval_reg;
    logic [TIME_W-1:0] mono_reg, mono_next;
    logic [WALL_W-1:0] wall_reg, wall_next;
    logic [TIME_W-1:0] boot_reg, boot_next;
    logic [TIME_W-1:0] last_update_reg, last_update_next;
    logic [TIME_W-1:0] held_reg, held_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [TIME_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]  below_reg, below_next;
    logic [CNT_W-1:0]  same_reg, same_next;
    logic              m_valid_reg, m_valid_next;
    logic [TIME_W-1:0] m_unix_reg, m_unix_next;

    logic              wr_en;
    logic [TIME_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_data;

    logic [TIME_W-1:0] elapsed;
    logic              sample_due;
    logic [CNT_W-1:0]  slot_plus;
    logic [CNT_W-1:0]  rank;
    logic [CNT_W:0]    below_same;
    logic              found;
    logic              last_cand;
    logic              out_free;

    mcoc_ring #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_unix_usec = m_unix_reg;

    assign elapsed    = s_mono_now_usec - last_update_reg;
    assign sample_due = elapsed >= {{(TIME_W-CFG_W){1'b0}}, interval_reg};
    assign slot_plus  = CNT_W'(slot_reg) + 1'b1;
    assign wr_data    = {1'b0, wall_reg} - mono_reg;
    assign rank       = fill_reg >> 1;
    assign below_same = {1'b0, below_reg} + {1'b0, same_reg};
    assign found      = (below_reg <= rank) && ({1'b0, rank} < below_same);
    assign last_cand  = (CNT_W'(i_reg) + 1'b1) >= fill_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = sample_due ? ST_WRITE : ST_RESULT;
                end
            end
            ST_WRITE: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_CAPT;
            ST_CAPT:  state_next = ST_SWEEP;
            ST_SWEEP: begin
                if (j_reg == fill_reg) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = (found || last_cand) ? ST_RESULT : ST_LOAD;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        wr_en            = 1'b0;
        rd_addr          = i_reg;
        mono_next        = mono_reg;
        wall_next        = wall_reg;
        boot_next        = boot_reg;
        last_update_next = last_update_reg;
        held_next        = held_reg;
        slot_next        = slot_reg;
        fill_next        = fill_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        cand_next        = cand_reg;
        below_next       = below_reg;
        same_next        = same_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_unix_next      = m_unix_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                mono_next = s_mono_now_usec;
                wall_next = s_wall_now_usec;
                boot_next = s_boot_usec;
            end
            ST_WRITE: begin
                wr_en            = 1'b1;
                last_update_next = mono_reg;
                slot_next        = (slot_plus == DEPTH_CNT) ? '0 : slot_plus[IDX_W-1:0];
                fill_next        = (fill_reg < slot_plus) ? slot_plus : fill_reg;
                i_next           = '0;
            end
            ST_LOAD: begin
                rd_addr = i_reg;
            end
            ST_CAPT: begin
                // candidate arrives now; start the sweep at entry zero
                cand_next  = rd_data;
                rd_addr    = '0;
                j_next     = CNT_W'(1);
                below_next = '0;
                same_next  = '0;
            end
            ST_SWEEP: begin
                // rd_data holds entry j-1, issued last cycle
                rd_addr = j_reg[IDX_W-1:0];
                if ($signed(rd_data) < $signed(cand_reg)) begin
                    below_next = below_reg + 1'b1;
                end else if (rd_data == cand_reg) begin
                    same_next = same_reg + 1'b1;
                end
                if (j_reg != fill_reg) begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_EVAL: begin
                if (found) begin
                    held_next = cand_reg;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_unix_next  = held_reg + boot_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            interval_reg    <= INTERVAL_RESET;
            last_update_reg <= '0;
            held_reg        <= '0;
            slot_reg        <= '0;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            last_update_reg <= last_update_next;
            held_reg        <= held_next;
            slot_reg        <= slot_next;
            fill_reg        <= fill_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                interval_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mono_reg   <= mono_next;
        wall_reg   <= wall_next;
        boot_reg   <= boot_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        cand_reg   <= cand_next;
        below_reg  <= below_next;
        same_reg   <= same_next;
        m_unix_reg <= m_unix_next;
    end

    // the last candidate must always hold the median rank
    a_median_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && last_cand) |-> found)
        else $error("median rank not found among ring entries");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= DEPTH_CNT) && (CNT_W'(slot_reg) < DEPTH_CNT))
        else $error("ring fill or write slot out of range");

    a_fill_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != $past(fill_reg)) |-> ($past(state_reg) == ST_WRITE))
        else $error("fill count moved outside a ring write");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (j_reg <= fill_reg && j_reg != '0))
        else $error("sweep index out of range");

endmodule
